@@ design/tvbs_pkg.sv @@
// Shared codes, limits and types for the typed value byte serializer.
`default_nettype none

package tvbs_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 3;

  localparam logic [CMD_W-1:0] CMD_RAW   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INT32 = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POS1  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POS2  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POS3  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BOOL  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BIT   = 3'd6;
  // unused code: sends nothing and leaves the bit accumulator alone
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd7;

  localparam logic [VALUE_W-1:0] POS1_LIMIT = 32'd128;
  localparam logic [VALUE_W-1:0] POS2_LIMIT = 32'd32768;
  localparam logic [VALUE_W-1:0] POS3_LIMIT = 32'd8388608;
  localparam logic [VALUE_W-1:0] OVERSIZE_MARK = 32'h8000_0000;
  localparam logic [BYTE_W-1:0]  BIT_MSB    = 8'h80;
  localparam logic [BYTE_W-1:0]  TRUE_BYTE  = 8'h01;

  // Encoded job: bytes left-aligned in word, count of bytes to send
  typedef struct packed {
    logic [VALUE_W-1:0] word;
    logic [COUNT_W-1:0] count;
  } enc_t;

endpackage

`default_nettype wire

@@ design/tvbs_in_if.sv @@
// Input channel: one typed value per beat.
`default_nettype none

interface tvbs_in_if;
  import tvbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] value;
  logic                      end_of_bits;

  modport source (output valid, output command, output value, output end_of_bits,
                  input ready);
  modport sink   (input valid, input command, input value, input end_of_bits,
                  output ready);
endinterface

`default_nettype wire

@@ design/tvbs_out_if.sv @@
// Output channel: one serialized byte per beat.
`default_nettype none

interface tvbs_out_if;
  import tvbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

@@ design/tvbs_encoder.sv @@
// Value encoder with the packed-bit accumulator.
`default_nettype none

module tvbs_encoder
  import tvbs_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [CMD_W-1:0]          command,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic                      end_of_bits,
  output enc_t                           enc
);

  logic [BYTE_W-1:0]  pending_bits, pending_bits_next;
  logic [COUNT_W-1:0] bit_count, bit_count_next;
  logic [VALUE_W-1:0] u;
  logic               nonzero;
  logic               not_pos;
  logic [BYTE_W-1:0]  bits_new;

  assign u        = value;
  assign nonzero  = (u != '0);
  assign not_pos  = u[VALUE_W-1] || !nonzero;
  assign bits_new = pending_bits | (nonzero ? (BIT_MSB >> bit_count) : '0);

  always_comb begin
    enc.word          = '0;
    enc.count         = '0;
    pending_bits_next = pending_bits;
    bit_count_next    = bit_count;
    case (command)
      CMD_RAW: begin
        enc.word  = {u[BYTE_W-1:0], {(VALUE_W-BYTE_W){1'b0}}};
        enc.count = 3'd1;
      end
      CMD_INT32: begin
        enc.word  = u;
        enc.count = 3'd4;
      end
      CMD_POS1: begin
        if (not_pos) begin
          enc.count = 3'd1;
        end else if (u < POS1_LIMIT) begin
          enc.word  = u << 24;
          enc.count = 3'd1;
        end else begin
          enc.word  = u | OVERSIZE_MARK;
          enc.count = 3'd4;
        end
      end
      CMD_POS2: begin
        if (not_pos) begin
          enc.count = 3'd2;
        end else if (u < POS2_LIMIT) begin
          enc.word  = u << 16;
          enc.count = 3'd2;
        end else begin
          enc.word  = u | OVERSIZE_MARK;
          enc.count = 3'd4;
        end
      end
      CMD_POS3: begin
        if (not_pos) begin
          enc.count = 3'd3;
        end else if (u < POS3_LIMIT) begin
          enc.word  = u << 8;
          enc.count = 3'd3;
        end else begin
          enc.word  = u | OVERSIZE_MARK;
          enc.count = 3'd4;
        end
      end
      CMD_BOOL: begin
        enc.word  = {(nonzero ? TRUE_BYTE : '0), {(VALUE_W-BYTE_W){1'b0}}};
        enc.count = 3'd1;
      end
      CMD_BIT: begin
        // flush on the eighth bit or on end of array, else keep collecting
        if (bit_count == 3'd7 || end_of_bits) begin
          enc.word          = {bits_new, {(VALUE_W-BYTE_W){1'b0}}};
          enc.count         = 3'd1;
          pending_bits_next = '0;
          bit_count_next    = '0;
        end else begin
          pending_bits_next = bits_new;
          bit_count_next    = bit_count + 3'd1;
        end
      end
      default: begin
        enc.count = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits <= '0;
      bit_count    <= '0;
    end else if (accept) begin
      pending_bits <= pending_bits_next;
      bit_count    <= bit_count_next;
    end
  end

endmodule

`default_nettype wire

@@ design/tvbs_emitter.sv @@
// Job register and output byte register: sends one byte per beat.
`default_nettype none

module tvbs_emitter
  import tvbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   accept,
  input  wire enc_t   enc,
  output logic        ready,
  tvbs_out_if.source  out_ch
);

  logic [VALUE_W-1:0] word;
  logic [COUNT_W-1:0] cnt;
  logic               ovalid;
  logic [BYTE_W-1:0]  obyte;
  logic               olast;
  logic               move;

  // advance a byte whenever the output register is free or draining
  assign move  = (cnt != '0) && (!ovalid || out_ch.ready);
  assign ready = (cnt == '0) || (cnt == 3'd1 && move);

  assign out_ch.valid    = ovalid;
  assign out_ch.out_byte = obyte;
  assign out_ch.last     = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      ovalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= enc.count;
      end else if (move) begin
        cnt <= cnt - 3'd1;
      end
      if (move) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= enc.word;
    end else if (move) begin
      word <= {word[VALUE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
    if (move) begin
      obyte <= word[VALUE_W-1 -: BYTE_W];
      olast <= (cnt == 3'd1);
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cnt > 3'd1) |-> !ready)
    else $error("input taken while job has bytes left");

  a_move_shows: assert property (@(posedge clk) disable iff (rst)
    move |=> ovalid)
    else $error("byte moved but output not valid");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (move && !accept) |=> (cnt == $past(cnt) - 3'd1))
    else $error("job count did not advance");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (cnt <= 3'd4))
    else $error("job count out of range");
`endif

endmodule

`default_nettype wire

@@ design/typed_value_byte_serializer_top.sv @@
// Top level of the typed value byte serializer.
`default_nettype none

// Each input beat carries a command, a 32-bit value and an end-of-bits flag; the block sends
// the value's bytes most significant first, one output beat per byte, with last set on the
// final byte of the item. An item sends as many bytes as its kind gives: 1 for raw, boolean,
// packed-bit flush and small positive integers, 2 to 4 for the wider kinds, 4 for int32 and
// for oversize positive integers; a packed bit that does not complete a byte, and an unused
// command, send nothing. Bytes leave through the single byte-wide output register; a new item
// is taken in the same cycle as the last byte of the previous one moves to the output register,
// so while the receiver does not stall, items follow with no gap.

module typed_value_byte_serializer_top
  import tvbs_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  tvbs_in_if.sink   in_ch,
  tvbs_out_if.source out_ch
);

  enc_t enc;
  logic ready;
  logic accept;

  assign in_ch.ready = ready;
  assign accept      = in_ch.valid && ready;

  tvbs_encoder u_encoder (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (in_ch.command),
    .value       (in_ch.value),
    .end_of_bits (in_ch.end_of_bits),
    .enc         (enc)
  );

  tvbs_emitter u_emitter (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .enc    (enc),
    .ready  (ready),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench for the typed value byte serializer: random and directed items, beat-level checks.
`timescale 1ns / 1ps

module tb;
  import tvbs_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_beat_t;

  // Predicts the byte stream from accepted items and checks each output beat against it.
  class serial_byte_checker;
    byte_beat_t         expected_bytes[$];
    logic [BYTE_W-1:0]  pending_bits;
    logic [COUNT_W-1:0] bit_count;
    int                 errors;

    function new();
      pending_bits = '0;
      bit_count    = '0;
      errors       = 0;
    endfunction

    function void push_byte(logic [BYTE_W-1:0] data, logic last);
      byte_beat_t beat;
      beat.data = data;
      beat.last = last;
      expected_bytes.push_back(beat);
    endfunction

    // Queue the low n bytes of word, most significant first.
    function void push_word(logic [VALUE_W-1:0] word, int n);
      logic [VALUE_W-1:0] shifted;
      for (int k = 0; k < n; k++) begin
        shifted = word >> (8 * (n - 1 - k));
        push_byte(shifted[BYTE_W-1:0], k == n - 1);
      end
    endfunction

    function void push_positive(logic [VALUE_W-1:0] word, int n, logic [VALUE_W-1:0] limit);
      if (word[VALUE_W-1] || word == '0) begin
        push_word('0, n);
      end else if (word < limit) begin
        push_word(word, n);
      end else begin
        push_word(word | OVERSIZE_MARK, 4);
      end
    endfunction

    function void note_item(logic [CMD_W-1:0] command, logic [VALUE_W-1:0] value,
                            logic end_of_bits);
      case (command)
        CMD_RAW:   push_byte(value[BYTE_W-1:0], 1'b1);
        CMD_INT32: push_word(value, 4);
        CMD_POS1:  push_positive(value, 1, POS1_LIMIT);
        CMD_POS2:  push_positive(value, 2, POS2_LIMIT);
        CMD_POS3:  push_positive(value, 3, POS3_LIMIT);
        CMD_BOOL:  push_byte((value != '0) ? TRUE_BYTE : 8'h00, 1'b1);
        CMD_BIT: begin
          if (value != '0) pending_bits = pending_bits | (BIT_MSB >> bit_count);
          // flush on the eighth bit or on the end flag
          if (bit_count == 3'd7 || end_of_bits) begin
            push_byte(pending_bits, 1'b1);
            pending_bits = '0;
            bit_count    = '0;
          end else begin
            bit_count = bit_count + 3'd1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [BYTE_W-1:0] data, logic last);
      byte_beat_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: beat %02h (last %0b) with nothing expected", data, last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tvbs_in_if  in_ch();
  tvbs_out_if out_ch();

  typed_value_byte_serializer_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  serial_byte_checker sb = new();

  int send_idle;
  int recv_stall;
  int hold_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // Receiver: long hold-off when requested, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Note the input beat before checking the output beat, so a same-edge byte finds its entry.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_item(in_ch.command, in_ch.value, in_ch.end_of_bits);
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_byte(out_ch.out_byte, out_ch.last);
  end

  task automatic send_item(input logic [CMD_W-1:0] command, input logic [VALUE_W-1:0] value,
                           input logic end_of_bits);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= command;
    in_ch.value       <= value;
    in_ch.end_of_bits <= end_of_bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_limit();
    case ($urandom_range(0, 2))
      0:       return POS1_LIMIT;
      1:       return POS2_LIMIT;
      default: return POS3_LIMIT;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 9: return $urandom;
      1:    return $urandom_range(0, 255);
      2:    return -$urandom_range(1, 1000);
      3:    return pick_limit() - 32'd1;
      4:    return pick_limit() + $urandom_range(0, 1);
      5:    return '0;
      6:    return 32'h7fff_ffff;
      7:    return 32'h8000_0000;
      default: return $urandom & 32'h00ff_ffff;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_bit();
    if ($urandom_range(0, 1) == 0) return '0;
    return ($urandom_range(0, 3) == 0) ? $urandom : 32'd1;
  endfunction

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int len;
    int pick;
    logic [CMD_W-1:0] command;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // well-formed bit array: length header, then bits, end flag on the last
        len = $urandom_range(1, 20);
        send_item(CMD_POS1, len, 1'($urandom_range(0, 1)));
        for (int i = 0; i < len; i++)
          send_item(CMD_BIT, pick_bit(), i == len - 1);
        sent += len + 1;
      end else if (pick < 32) begin
        // broken array: bits with no end flag, left pending across other items
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_item(CMD_BIT, pick_bit(), 1'b0);
        sent += len;
      end else begin
        command = CMD_W'($urandom_range(0, 7));
        send_item(command, pick_value(), 1'($urandom_range(0, 1)));
        if (command != CMD_NONE) sent++;
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_RAW;
    in_ch.value       = '0;
    in_ch.end_of_bits = 1'b0;
    out_ch.ready      = 1'b0;
    send_idle         = 0;
    recv_stall        = 0;
    hold_left         = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of each kind
    send_item(CMD_RAW,   32'hABCD_EF5A, 1'b0);
    send_item(CMD_RAW,   32'h0000_0000, 1'b1);
    send_item(CMD_INT32, 32'h8000_0000, 1'b0);
    send_item(CMD_INT32, 32'h7fff_ffff, 1'b0);
    send_item(CMD_INT32, 32'hffff_ffff, 1'b1);
    send_item(CMD_POS1,  32'd0, 1'b0);
    send_item(CMD_POS1,  -32'sd5, 1'b0);
    send_item(CMD_POS1,  32'd1, 1'b0);
    send_item(CMD_POS1,  POS1_LIMIT - 32'd1, 1'b0);
    send_item(CMD_POS1,  POS1_LIMIT, 1'b0);
    send_item(CMD_POS2,  POS2_LIMIT - 32'd1, 1'b0);
    send_item(CMD_POS2,  POS2_LIMIT, 1'b1);
    send_item(CMD_POS3,  POS3_LIMIT - 32'd1, 1'b0);
    send_item(CMD_POS3,  POS3_LIMIT, 1'b0);
    send_item(CMD_POS3,  32'h7fff_ffff, 1'b0);
    send_item(CMD_BOOL,  32'd0, 1'b0);
    send_item(CMD_BOOL,  32'h8000_0000, 1'b0);
    send_item(CMD_NONE,  32'hffff_ffff, 1'b1);
    // partial bit byte held across other items, then flushed
    send_item(CMD_BIT,   32'd1, 1'b0);
    send_item(CMD_RAW,   32'h0000_0033, 1'b1);
    send_item(CMD_BIT,   32'd0, 1'b0);
    send_item(CMD_BIT,   32'h0000_0100, 1'b1);
    run_random(40);

    send_idle = 45;
    run_random(45);

    // pause the sender until the stream has drained
    in_ch.valid <= 1'b0;
    wait_drained();

    // long receiver hold-off while items keep coming, so the input stalls
    send_idle  = 0;
    recv_stall = 45;
    hold_left  = 80;
    run_random(45);

    send_idle  = 37;
    recv_stall = 37;
    run_random(50);

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tvbs_pkg.sv
design/tvbs_in_if.sv
design/tvbs_out_if.sv
design/tvbs_encoder.sv
design/tvbs_emitter.sv
design/typed_value_byte_serializer_top.sv
test/tb.sv
